FILE: rtl/core/mcmr_pkg.sv
package mcmr_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int SMP_W       = 32;
    localparam int OUT_W       = 36;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
    // Exact sum of up to MAX_SOURCES signed samples.
    localparam int ACC_W       = SMP_W + $clog2(MAX_SOURCES);
    // Compare width that holds both the accumulator and the saturation limits.
    localparam int CMP_W       = (ACC_W > OUT_W) ? ACC_W : OUT_W + 1;
    localparam int STEP_W      = $clog2(ACC_W);

    localparam logic signed [SMP_W-1:0] OUT_NODATA_RST = -32'sd9999;

    localparam logic signed [CMP_W-1:0] SAT_MAX =
        {{(CMP_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [CMP_W-1:0] SAT_MIN =
        {{(CMP_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_FIRST = 3'd0,
        MODE_LAST  = 3'd1,
        MODE_MIN   = 3'd2,
        MODE_MAX   = 3'd3,
        MODE_AVG   = 3'd4,
        MODE_SUM   = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MERGE_MODE = 2'd0,
        REG_OUT_NODATA = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_ACCUM = 2'd0,
        ST_CLOSE = 2'd1,
        ST_DIV   = 2'd2,
        ST_EMIT  = 2'd3
    } state_t;

    typedef struct packed {
        logic take;
        logic div_start;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/mosaic_cell_merge_reducer_top.sv
// Mosaic cell merge reducer.
// Input channel (in_valid/in_ready) carries one candidate per request: sample, covered,
// src_nodata and cell_end. Candidates that are not covered or equal their source nodata
// are skipped. The request with cell_end closes the cell and yields one result on the
// output channel (out_valid/out_ready): merged, empty_res and overflow.
// Candidates without cell_end are taken one per cycle. After a cell_end request the
// input is held off until the result is loaded into the output register; for average
// over a nonempty cell a one-bit-per-cycle restoring divider first walks the whole
// accumulator width.
// The output register parts the two channels: while a finished result waits on
// out_ready, candidates of the next cell keep being taken; only the next cell close
// waits for the register to free up.
// The user must write registers through cfg_we/cfg_idx/cfg_wdata only while the block
// is idle; it does not enforce this. Index 0 merge mode, index 1 output nodata value.
// Reset (rst_n low, asynchronous) selects the first mode, sets the output nodata
// value to -9999 and clears the cell state and the output valid flag.
module mosaic_cell_merge_reducer_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [mcmr_pkg::SMP_W-1:0]       sample,
    input  logic                                    covered,
    input  logic signed [mcmr_pkg::SMP_W-1:0]       src_nodata,
    input  logic                                    cell_end,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [mcmr_pkg::OUT_W-1:0]       merged,
    output logic                                    empty_res,
    output logic                                    overflow,
    input  logic                                    cfg_we,
    input  logic        [mcmr_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic        [mcmr_pkg::SMP_W-1:0]       cfg_wdata
);

    mcmr_pkg::ctrl_cmd_t    cmd;
    mcmr_pkg::dp_status_t   status;

    mcmr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cell_end (cell_end),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mcmr_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample     (sample),
        .covered    (covered),
        .src_nodata (src_nodata),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .merged     (merged),
        .empty_res  (empty_res),
        .overflow   (overflow)
    );

`ifndef SYNTHESIS
    // A closing request must stop the input until its result has been produced.
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cell_end) |=> !in_ready)
        else $error("input still ready after a cell was closed");

    // An empty cell never reports overflow.
    a_empty_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_res) |-> !overflow)
        else $error("empty cell flagged with overflow");

    // A new result only appears after the input was held off for the close.
    a_result_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the input was accepting");
`endif

endmodule

FILE: rtl/core/mcmr_ctrl.sv
module mcmr_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   cell_end,
    input  mcmr_pkg::dp_status_t   status,
    output logic                   in_ready,
    output mcmr_pkg::ctrl_cmd_t    cmd
);

    mcmr_pkg::state_t state_reg;
    mcmr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcmr_pkg::ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mcmr_pkg::ST_ACCUM:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (cell_end)
                    begin
                        state_next = mcmr_pkg::ST_CLOSE;
                    end
                end
            end
            mcmr_pkg::ST_CLOSE:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = mcmr_pkg::ST_DIV;
                end
                else
                begin
                    state_next = mcmr_pkg::ST_EMIT;
                end
            end
            mcmr_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = mcmr_pkg::ST_EMIT;
                end
            end
            mcmr_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mcmr_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = mcmr_pkg::ST_ACCUM;
            end
        endcase
    end

endmodule

FILE: rtl/core/mcmr_div.sv
module mcmr_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mcmr_pkg::ACC_W-1:0]   dividend,
    input  logic        [mcmr_pkg::CNT_W-1:0]   divisor,
    output logic                                done,
    output logic signed [mcmr_pkg::ACC_W-1:0]   quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [mcmr_pkg::STEP_W-1:0]        step_reg;
    logic [mcmr_pkg::ACC_W-1:0]         quo_reg;
    logic [mcmr_pkg::CNT_W-1:0]         rem_reg;
    logic [mcmr_pkg::CNT_W-1:0]         dvs_reg;
    logic                               neg_reg;

    logic [mcmr_pkg::CNT_W:0]           rem_sh;
    logic [mcmr_pkg::CNT_W:0]           rem_diff;
    logic                               fits;
    logic [mcmr_pkg::CNT_W-1:0]         rem_next;
    logic [mcmr_pkg::ACC_W-1:0]         quo_next;

    // One restoring step per cycle on the magnitude; the sign is applied at the end,
    // which gives truncation toward zero.
    assign rem_sh   = {rem_reg, quo_reg[mcmr_pkg::ACC_W-1]};
    assign fits     = (rem_sh >= {1'b0, dvs_reg});
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign rem_next = fits ? rem_diff[mcmr_pkg::CNT_W-1:0] : rem_sh[mcmr_pkg::CNT_W-1:0];
    assign quo_next = {quo_reg[mcmr_pkg::ACC_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= mcmr_pkg::STEP_W'(mcmr_pkg::ACC_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[mcmr_pkg::ACC_W-1];
            quo_reg <= dividend[mcmr_pkg::ACC_W-1] ? -dividend : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

FILE: rtl/core/mcmr_datapath.sv
module mcmr_datapath
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mcmr_pkg::ctrl_cmd_t                     cmd,
    output mcmr_pkg::dp_status_t                    status,
    input  logic signed [mcmr_pkg::SMP_W-1:0]       sample,
    input  logic                                    covered,
    input  logic signed [mcmr_pkg::SMP_W-1:0]       src_nodata,
    input  logic                                    cfg_we,
    input  logic        [mcmr_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic        [mcmr_pkg::SMP_W-1:0]       cfg_wdata,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic signed [mcmr_pkg::OUT_W-1:0]       merged,
    output logic                                    empty_res,
    output logic                                    overflow
);

    logic        [mcmr_pkg::MODE_W-1:0]     mode_reg;
    logic signed [mcmr_pkg::SMP_W-1:0]      nodata_reg;
    logic        [mcmr_pkg::CNT_W-1:0]      cnt_reg;
    logic                                   ovf_reg;
    logic signed [mcmr_pkg::SMP_W-1:0]      first_reg;
    logic signed [mcmr_pkg::SMP_W-1:0]      last_reg;
    logic signed [mcmr_pkg::SMP_W-1:0]      min_reg;
    logic signed [mcmr_pkg::SMP_W-1:0]      max_reg;
    logic signed [mcmr_pkg::ACC_W-1:0]      sum_reg;
    logic                                   out_valid_reg;
    logic signed [mcmr_pkg::OUT_W-1:0]      merged_reg;
    logic                                   empty_reg;
    logic                                   ovf_out_reg;

    logic                                   smp_ok;
    logic                                   full;
    logic                                   first_smp;
    logic signed [mcmr_pkg::ACC_W-1:0]      sum_base;
    logic                                   div_done;
    logic signed [mcmr_pkg::ACC_W-1:0]      quotient;
    logic signed [mcmr_pkg::CMP_W-1:0]      sum_ext;
    logic signed [mcmr_pkg::CMP_W-1:0]      quo_ext;
    logic signed [mcmr_pkg::OUT_W-1:0]      sum_sat;
    logic signed [mcmr_pkg::OUT_W-1:0]      merged_next;

    assign smp_ok    = covered && (sample != src_nodata);
    assign full      = (cnt_reg == mcmr_pkg::CNT_W'(mcmr_pkg::MAX_SOURCES));
    assign first_smp = (cnt_reg == '0);
    assign sum_base  = first_smp ? '0 : sum_reg;

    mcmr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sum_ext = mcmr_pkg::CMP_W'(sum_reg);
    assign quo_ext = mcmr_pkg::CMP_W'(quotient);

    always_comb
    begin
        if (sum_ext > mcmr_pkg::SAT_MAX)
        begin
            sum_sat = mcmr_pkg::SAT_MAX[mcmr_pkg::OUT_W-1:0];
        end
        else if (sum_ext < mcmr_pkg::SAT_MIN)
        begin
            sum_sat = mcmr_pkg::SAT_MIN[mcmr_pkg::OUT_W-1:0];
        end
        else
        begin
            sum_sat = sum_ext[mcmr_pkg::OUT_W-1:0];
        end
    end

    always_comb
    begin
        if (first_smp)
        begin
            merged_next = mcmr_pkg::OUT_W'(nodata_reg);
        end
        else
        begin
            unique case (mode_reg)
                mcmr_pkg::MODE_LAST: merged_next = mcmr_pkg::OUT_W'(last_reg);
                mcmr_pkg::MODE_MIN:  merged_next = mcmr_pkg::OUT_W'(min_reg);
                mcmr_pkg::MODE_MAX:  merged_next = mcmr_pkg::OUT_W'(max_reg);
                mcmr_pkg::MODE_AVG:  merged_next = quo_ext[mcmr_pkg::OUT_W-1:0];
                mcmr_pkg::MODE_SUM:  merged_next = sum_sat;
                default:             merged_next = mcmr_pkg::OUT_W'(first_reg);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mcmr_pkg::MODE_FIRST;
            nodata_reg    <= mcmr_pkg::OUT_NODATA_RST;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == mcmr_pkg::REG_MERGE_MODE)
                begin
                    mode_reg <= cfg_wdata[mcmr_pkg::MODE_W-1:0];
                end
                else if (cfg_idx == mcmr_pkg::REG_OUT_NODATA)
                begin
                    nodata_reg <= signed'(cfg_wdata);
                end
            end

            if (cmd.emit)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.take && smp_ok)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample registers are only meaningful once the count is nonzero.
    always_ff @(posedge clk)
    begin
        if (cmd.take && smp_ok && !full)
        begin
            last_reg <= sample;
            sum_reg  <= sum_base + mcmr_pkg::ACC_W'(sample);
            if (first_smp)
            begin
                first_reg <= sample;
                min_reg   <= sample;
                max_reg   <= sample;
            end
            else
            begin
                if (sample < min_reg)
                begin
                    min_reg <= sample;
                end
                if (sample > max_reg)
                begin
                    max_reg <= sample;
                end
            end
        end

        if (cmd.emit)
        begin
            merged_reg  <= merged_next;
            empty_reg   <= first_smp;
            ovf_out_reg <= ovf_reg && !first_smp;
        end
    end

    assign status.need_div = (mode_reg == mcmr_pkg::MODE_AVG) && !first_smp;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign merged    = merged_reg;
    assign empty_res = empty_reg;
    assign overflow  = ovf_out_reg;

endmodule
